@@ rtl/core/unimodal_minimum_probe_sequencer_unit_defines.svh @@
// Assertion helpers used by the probe sequencer RTL.
`ifndef UNIMODAL_MINIMUM_PROBE_SEQUENCER_UNIT_DEFINES_SVH
`define UNIMODAL_MINIMUM_PROBE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UMPS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UMPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/umps_pkg.sv @@
package umps_pkg;

    // Input command codes
    typedef enum logic {
        CMD_RESTART = 1'b0,
        CMD_REPORT  = 1'b1
    } cmd_t;

    // Configuration register indexes
    localparam logic [0:0] REG_RANGE_START = 1'b0;
    localparam logic [0:0] REG_RANGE_END   = 1'b1;

    // Register reset values
    localparam logic [7:0] RANGE_START_RST = 8'd0;
    localparam logic [7:0] RANGE_END_RST   = 8'd4;

    // Point count at which focus mode keeps climbing from the low side
    localparam int unsigned FOCUS_LOW_RUN_MIN = 7;

    // One result beat
    typedef struct packed {
        logic [7:0] next_attempt;
        logic       finished;
        logic [8:0] attempts_made;
    } result_t;

endpackage

@@ rtl/core/unimodal_minimum_probe_sequencer_unit.sv @@
// Channel   Direction  Handshake               Payload
// s_        in         s_valid / s_ready       s_command, s_cost
// m_        out        m_valid / m_ready       m_next_attempt, m_finished, m_attempts_made
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat per cycle while s_ready is high; the result of each s_ beat is registered
// into the output buffer. The cost memory is read ahead, registered, at the neighbor
// index of the next state, with the same-cycle write forwarded, so no stall is needed.
// Reset is synchronous; the cost memory has no clearing pass, entries are only
// read after the search has written them. A two-entry output buffer keeps s_ready
// high while one result waits on m_ready; s_ready drops only when both are full.
module unimodal_minimum_probe_sequencer_unit #(
    parameter int MAX_POINTS = 16,
    parameter int COST_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // report / restart beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [31:0] s_cost,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_next_attempt,
    output logic        m_finished,
    output logic [8:0]  m_attempts_made,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

`include "unimodal_minimum_probe_sequencer_unit_defines.svh"

    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam logic [IW-1:0] MAX_IW = IW'(MAX_POINTS);
    localparam logic signed [9:0] MAX_PTS_S = 10'(MAX_POINTS);
    localparam int RST_SPAN = int'(umps_pkg::RANGE_END_RST)
                            - int'(umps_pkg::RANGE_START_RST) + 1;
    localparam int RST_PC = (RST_SPAN < 2) ? 2
                          : ((RST_SPAN > MAX_POINTS) ? MAX_POINTS : RST_SPAN);

    // Registers
    logic [7:0]            range_start_reg, range_end_reg;
    logic [7:0]            base_reg, base_next;
    logic [IW-1:0]         pc_reg, pc_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [IW-1:0]         done_reg, done_next;
    logic                  focus_reg, focus_next;
    logic [IW-1:0]         lower_reg, lower_next;
    logic [IW-1:0]         upper_reg, upper_next;

    logic [COST_BITS-1:0]  cost_mem [MAX_POINTS];
    logic [COST_BITS-1:0]  rdata_reg;
    logic [COST_BITS-1:0]  fwd_data_reg;
    logic                  fwd_reg, fwd_next;
    logic [COST_BITS-1:0]  s0_reg, s1_reg;

    umps_pkg::result_t     out_reg, skid_reg, res_next;
    logic                  out_valid_reg, skid_valid_reg;

    // Datapath signals
    logic                  s_fire;
    logic                  is_report;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr_next;
    logic [COST_BITS-1:0]  cost_m;
    logic [COST_BITS-1:0]  nb;
    logic signed [9:0]     span;
    logic [IW-1:0]         restart_pc;
    logic [IW-1:0]         last;

    assign s_ready   = !skid_valid_reg;
    assign s_fire    = s_valid && s_ready;
    assign is_report = (s_command == umps_pkg::CMD_REPORT);
    assign cfg_ready = 1'b1;

    assign cost_m = COST_BITS'({32'd0, s_cost});
    assign nb     = fwd_reg ? fwd_data_reg : rdata_reg;
    assign last   = pc_reg - IW'(1);
    assign waddr  = AW'(cur_reg);

    // Point count on restart, clamped to 2..MAX_POINTS
    assign span = $signed({2'b00, range_end_reg}) - $signed({2'b00, range_start_reg}) + 10'sd1;
    always_comb begin
        if (span < 10'sd2) begin
            restart_pc = IW'(2);
        end else if (span > MAX_PTS_S) begin
            restart_pc = MAX_IW;
        end else begin
            restart_pc = IW'(span);
        end
    end

    // Next search state
    always_comb begin
        base_next  = base_reg;
        pc_next    = pc_reg;
        cur_next   = cur_reg;
        done_next  = done_reg;
        focus_next = focus_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        we         = 1'b0;
        if (s_fire && !is_report) begin
            base_next  = range_start_reg;
            pc_next    = restart_pc;
            cur_next   = '0;
            done_next  = '0;
            focus_next = 1'b0;
            lower_next = '0;
            upper_next = '0;
        end else if (s_fire && done_reg < pc_reg) begin
            we        = (cur_reg < MAX_IW);
            done_next = done_reg + IW'(1);
            cur_next  = cur_reg + IW'(1);
            if (cur_reg == IW'(1)) begin
                // second probe: jump to the far end unless flat
                if (s0_reg != cost_m) begin
                    cur_next = last;
                end
            end else if (cur_reg == last) begin
                // both ends known: rising, falling or walk
                if (s0_reg < s1_reg && s1_reg < cost_m) begin
                    done_next = pc_reg;
                    cur_next  = cur_reg;
                end else if (s0_reg > s1_reg && s1_reg > cost_m) begin
                    focus_next = 1'b1;
                    lower_next = IW'(1);
                    upper_next = pc_reg - IW'(2);
                    cur_next   = pc_reg - IW'(2);
                end else begin
                    cur_next = IW'(2);
                end
            end else if (focus_reg) begin
                if (cur_reg == upper_reg) begin
                    if (cost_m > nb) begin
                        done_next = pc_reg;
                        cur_next  = cur_reg;
                    end else begin
                        lower_next = lower_reg + IW'(1);
                        cur_next   = lower_reg + IW'(1);
                    end
                end else if (cur_reg == lower_reg) begin
                    if (cur_reg != '0 && cost_m > nb) begin
                        done_next = pc_reg;
                        cur_next  = cur_reg;
                    end else if (32'(pc_reg) >= umps_pkg::FOCUS_LOW_RUN_MIN) begin
                        lower_next = lower_reg + IW'(1);
                        cur_next   = lower_reg + IW'(1);
                    end else begin
                        upper_next = upper_reg - IW'(1);
                        cur_next   = upper_reg - IW'(1);
                    end
                end
            end else if (cur_reg != '0 && cost_m > nb) begin
                // walk in order, stop on a rise
                done_next = pc_reg;
                cur_next  = cur_reg;
            end
        end
    end

    // Neighbor read address for the next beat, forward a same-entry write
    always_comb begin
        if (focus_next && cur_next == upper_next) begin
            raddr_next = AW'(cur_next + IW'(1));
        end else begin
            raddr_next = AW'(cur_next - IW'(1));
        end
        fwd_next = we && (waddr == raddr_next);
    end

    // Result for this beat
    always_comb begin
        res_next.next_attempt  = base_next + 8'(cur_next);
        res_next.finished      = (done_next >= pc_next);
        res_next.attempts_made = 9'(done_next);
    end

    // Control state, registers and output buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= umps_pkg::RANGE_START_RST;
            range_end_reg   <= umps_pkg::RANGE_END_RST;
            base_reg        <= umps_pkg::RANGE_START_RST;
            pc_reg          <= IW'(RST_PC);
            cur_reg         <= '0;
            done_reg        <= '0;
            focus_reg       <= 1'b0;
            lower_reg       <= '0;
            upper_reg       <= '0;
            fwd_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    umps_pkg::REG_RANGE_START: range_start_reg <= cfg_data;
                    umps_pkg::REG_RANGE_END:   range_end_reg   <= cfg_data;
                    default: ;
                endcase
            end
            base_reg  <= base_next;
            pc_reg    <= pc_next;
            cur_reg   <= cur_next;
            done_reg  <= done_next;
            focus_reg <= focus_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            fwd_reg   <= fwd_next;

            if (s_fire) begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_ready && out_valid_reg) begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (!out_valid_reg || m_ready) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end else if (m_ready && out_valid_reg && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    // Cost memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            cost_mem[waddr] <= cost_m;
        end
        rdata_reg <= cost_mem[raddr_next];
    end

    // Forward data and copies of the two low entries
    always_ff @(posedge aclk) begin
        fwd_data_reg <= cost_m;
        if (we && cur_reg == '0) begin
            s0_reg <= cost_m;
        end
        if (we && cur_reg == IW'(1)) begin
            s1_reg <= cost_m;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_next_attempt  = out_reg.next_attempt;
    assign m_finished      = out_reg.finished;
    assign m_attempts_made = out_reg.attempts_made;

    // Checks
    `UMPS_ASSERT_SAME(a_skid_behind_main, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid holds a beat while main is empty")
    `UMPS_ASSERT_SAME(a_done_bounded, aclk, aresetn, 1'b1, done_reg <= pc_reg && pc_reg >= IW'(2), "attempt count past point count")
    `UMPS_ASSERT_NEXT(a_restart_clears, aclk, aresetn, s_fire && s_command == umps_pkg::CMD_RESTART, done_reg == '0 && !focus_reg && cur_reg == '0, "restart left search state")
    `UMPS_ASSERT_NEXT(a_finished_holds, aclk, aresetn, s_fire && s_command == umps_pkg::CMD_REPORT && done_reg >= pc_reg, cur_reg == $past(cur_reg) && done_reg == $past(done_reg), "report after finish changed state")

endmodule
